// ===== src/tiled_quad_strip_vertex_generator_unit_defines.svh =====
// assertion macros for the tiled quad strip vertex generator
// used by the unit and the tile sequencer under src, no other dependencies
`ifndef TILED_QUAD_STRIP_VERTEX_GENERATOR_UNIT_DEFINES_SVH
`define TILED_QUAD_STRIP_VERTEX_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define TQSVG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define TQSVG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tqsvg_pkg.sv =====
// shared types and constants of the tiled quad strip vertex generator
// no dependencies
`default_nettype none

package tqsvg_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_TILES_ACROSS = 3'd0;
  localparam logic [2:0] CFG_TILES_DOWN   = 3'd1;
  localparam logic [2:0] CFG_TILE_WIDTH   = 3'd2;
  localparam logic [2:0] CFG_TILE_HEIGHT  = 3'd3;
  localparam logic [2:0] CFG_AREA_WIDTH   = 3'd4;
  localparam logic [2:0] CFG_AREA_HEIGHT  = 3'd5;
  localparam logic [2:0] CFG_VISIBLE      = 3'd6;

  // strip index advance after the first tile and after every later tile
  localparam logic [15:0] IDX_STEP_FIRST = 16'd4;
  localparam logic [15:0] IDX_STEP       = 16'd6;

  typedef struct packed {
    logic [15:0] start_vertex;
    logic        apply_transform;
    logic [31:0] coef_xx;
    logic [31:0] coef_yx;
    logic [31:0] coef_xy;
    logic [31:0] coef_yy;
    logic [31:0] offset_x;
    logic [31:0] offset_y;
  } req_t;

  typedef struct packed {
    logic [15:0] first_index;
    logic        stitch_previous;
    logic        last_tile;
  } tile_tag_t;

  // local tile edges, q16.16
  typedef struct packed {
    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] y0;
    logic [31:0] y1;
  } local_t;

  typedef struct packed {
    logic [31:0] top_left_x;
    logic [31:0] top_left_y;
    logic [31:0] bottom_left_x;
    logic [31:0] bottom_left_y;
    logic [31:0] top_right_x;
    logic [31:0] top_right_y;
    logic [31:0] bottom_right_x;
    logic [31:0] bottom_right_y;
    tile_tag_t   tag;
  } result_t;

endpackage

`default_nettype wire

// ===== src/tiled_quad_strip_vertex_generator_unit.sv =====
// One draw request covers a grid of tiles_across by tiles_down tiles and yields
// one result item per tile, row by row, left to right, with the four corners,
// the strip index of the tile's first new vertex, a stitch flag and tlast on
// the final tile. Results leave at one tile per cycle while the result channel
// does not stall. The tile sequencer takes no new request while it is busy
// with one, and takes the next request in the cycle after it has issued the
// last tile of the current one; an empty grid takes its request and issues
// nothing. The first result passes through a five-stage pipeline: sequencer,
// edge products, clipping, transform products and the final sums.
// Configuration is to be written by the user only while no request is in
// flight; the unit does not enforce this. Every register write is taken at
// once.
// Depends on tqsvg_pkg, tqsvg_tile_seq, tqsvg_xform and the macro header.
`default_nettype none
`include "tiled_quad_strip_vertex_generator_unit_defines.svh"

module tiled_quad_strip_vertex_generator_unit import tqsvg_pkg::*; #(
  parameter int MAX_TILES_ACROSS = 8,
  parameter int MAX_TILES_DOWN   = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // request channel
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // start_vertex[15:0], coef_xx[47:16], coef_yx[79:48], coef_xy[111:80],
  // coef_yy[143:112], offset_x[175:144], offset_y[207:176]
  input  wire logic [207:0] s_axis_tdata_i,
  // apply_transform[0]
  input  wire logic [0:0]   s_axis_tuser_i,
  // result channel
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // top_left_x[31:0], top_left_y[63:32], bottom_left_x[95:64],
  // bottom_left_y[127:96], top_right_x[159:128], top_right_y[191:160],
  // bottom_right_x[223:192], bottom_right_y[255:224], first_index[271:256]
  output logic [271:0]      m_axis_tdata_o,
  // stitch_previous[0]
  output logic [0:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o,
  // configuration write channel
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  localparam int XW  = $clog2(MAX_TILES_ACROSS + 1);
  localparam int YW  = $clog2(MAX_TILES_DOWN + 1);
  localparam int XPW = 31 + XW;
  localparam int YPW = 31 + YW;

  logic [3:0]  tiles_across_q;
  logic [3:0]  tiles_down_q;
  logic [30:0] tile_width_q;
  logic [30:0] tile_height_q;
  logic [30:0] area_width_q;
  logic [30:0] area_height_q;
  logic        visible_q;

  logic [XW-1:0] n_across;
  logic [YW-1:0] n_down;
  logic          en;

  req_t          in_req;
  logic          t_valid;
  logic [XW-1:0] t_x;
  logic [YW-1:0] t_y;
  tile_tag_t     t_tag;
  req_t          t_req;

  logic           s2_valid_q;
  tile_tag_t      s2_tag_q;
  req_t           s2_req_q;
  logic [XPW-1:0] s2_ax_q, s2_bx_q;
  logic [YPW-1:0] s2_ay_q, s2_by_q;

  logic      s3_valid_q;
  tile_tag_t s3_tag_q;
  req_t      s3_req_q;
  local_t    s3_loc_q;

  logic    out_valid;
  result_t out_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiles_across_q <= 4'd1;
      tiles_down_q   <= 4'd1;
      tile_width_q   <= 31'd65536;
      tile_height_q  <= 31'd65536;
      area_width_q   <= 31'd65536;
      area_height_q  <= 31'd65536;
      visible_q      <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TILES_ACROSS: tiles_across_q <= cfg_data_i[3:0];
        CFG_TILES_DOWN:   tiles_down_q   <= cfg_data_i[3:0];
        CFG_TILE_WIDTH:   tile_width_q   <= cfg_data_i[30:0];
        CFG_TILE_HEIGHT:  tile_height_q  <= cfg_data_i[30:0];
        CFG_AREA_WIDTH:   area_width_q   <= cfg_data_i[30:0];
        CFG_AREA_HEIGHT:  area_height_q  <= cfg_data_i[30:0];
        CFG_VISIBLE:      visible_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // counts above the limit saturate
  assign n_across = (tiles_across_q > 4'(MAX_TILES_ACROSS)) ? XW'(MAX_TILES_ACROSS)
                                                             : XW'(tiles_across_q);
  assign n_down   = (tiles_down_q > 4'(MAX_TILES_DOWN)) ? YW'(MAX_TILES_DOWN)
                                                         : YW'(tiles_down_q);

  // the whole pipeline moves when the output register is free or drained
  assign en = !m_axis_tvalid_o || m_axis_tready_i;

  assign in_req.start_vertex    = s_axis_tdata_i[15:0];
  assign in_req.apply_transform = s_axis_tuser_i[0];
  assign in_req.coef_xx         = s_axis_tdata_i[47:16];
  assign in_req.coef_yx         = s_axis_tdata_i[79:48];
  assign in_req.coef_xy         = s_axis_tdata_i[111:80];
  assign in_req.coef_yy         = s_axis_tdata_i[143:112];
  assign in_req.offset_x        = s_axis_tdata_i[175:144];
  assign in_req.offset_y        = s_axis_tdata_i[207:176];

  tqsvg_tile_seq #(
    .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
    .MAX_TILES_DOWN   (MAX_TILES_DOWN)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .req_valid_i  (s_axis_tvalid_i),
    .req_ready_o  (s_axis_tready_o),
    .req_i        (in_req),
    .n_across_i   (n_across),
    .n_down_i     (n_down),
    .tile_valid_o (t_valid),
    .tile_x_o     (t_x),
    .tile_y_o     (t_y),
    .tag_o        (t_tag),
    .req_o        (t_req)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= t_valid;
      s3_valid_q <= s2_valid_q;
    end
  end

  // near and far edges as exact products; zero when hidden
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_tag_q <= t_tag;
      s2_req_q <= t_req;
      if (visible_q) begin
        s2_ax_q <= XPW'(tile_width_q) * XPW'(t_x);
        s2_bx_q <= XPW'(tile_width_q) * (XPW'(t_x) + XPW'(1));
        s2_ay_q <= YPW'(tile_height_q) * YPW'(t_y);
        s2_by_q <= YPW'(tile_height_q) * (YPW'(t_y) + YPW'(1));
      end else begin
        s2_ax_q <= '0;
        s2_bx_q <= '0;
        s2_ay_q <= '0;
        s2_by_q <= '0;
      end
    end
  end

  // near edge wraps to 32 bits, far edge clips to the area
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_tag_q    <= s2_tag_q;
      s3_req_q    <= s2_req_q;
      s3_loc_q.x0 <= s2_ax_q[31:0];
      s3_loc_q.y0 <= s2_ay_q[31:0];
      s3_loc_q.x1 <= (s2_bx_q > XPW'(area_width_q)) ? {1'b0, area_width_q} : s2_bx_q[31:0];
      s3_loc_q.y1 <= (s2_by_q > YPW'(area_height_q)) ? {1'b0, area_height_q} : s2_by_q[31:0];
    end
  end

  tqsvg_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_valid_q),
    .tag_i   (s3_tag_q),
    .req_i   (s3_req_q),
    .loc_i   (s3_loc_q),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign m_axis_tvalid_o          = out_valid;
  assign m_axis_tdata_o[31:0]     = out_res.top_left_x;
  assign m_axis_tdata_o[63:32]    = out_res.top_left_y;
  assign m_axis_tdata_o[95:64]    = out_res.bottom_left_x;
  assign m_axis_tdata_o[127:96]   = out_res.bottom_left_y;
  assign m_axis_tdata_o[159:128]  = out_res.top_right_x;
  assign m_axis_tdata_o[191:160]  = out_res.top_right_y;
  assign m_axis_tdata_o[223:192]  = out_res.bottom_right_x;
  assign m_axis_tdata_o[255:224]  = out_res.bottom_right_y;
  assign m_axis_tdata_o[271:256]  = out_res.tag.first_index;
  assign m_axis_tuser_o[0]        = out_res.tag.stitch_previous;
  assign m_axis_tlast_o           = out_res.tag.last_tile;

  `TQSVG_ASSERT_NEXT(a_s2_holds_on_stall, clk_i, rst_ni, s2_valid_q && !en, s2_valid_q,
    "edge stage lost an item during a stall")
  `TQSVG_ASSERT_NEXT(a_s3_holds_on_stall, clk_i, rst_ni, s3_valid_q && !en, s3_valid_q,
    "clip stage lost an item during a stall")
  `TQSVG_ASSERT_NEXT(a_out_holds_on_stall, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o), "result item changed while stalled")

endmodule

`default_nettype wire

// ===== src/tqsvg_tile_seq.sv =====
// tile sequencer: walks the tile grid of one request, one tile per cycle while en_i is high
// depends on tqsvg_pkg and the assertion macro header
`default_nettype none
`include "tiled_quad_strip_vertex_generator_unit_defines.svh"

module tqsvg_tile_seq import tqsvg_pkg::*; #(
  parameter int MAX_TILES_ACROSS = 8,
  parameter int MAX_TILES_DOWN   = 8,
  localparam int XW = $clog2(MAX_TILES_ACROSS + 1),
  localparam int YW = $clog2(MAX_TILES_DOWN + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire req_t          req_i,
  input  wire logic [XW-1:0] n_across_i,
  input  wire logic [YW-1:0] n_down_i,
  output logic               tile_valid_o,
  output logic [XW-1:0]      tile_x_o,
  output logic [YW-1:0]      tile_y_o,
  output tile_tag_t          tag_o,
  output req_t               req_o
);

  logic          busy_q;
  logic          first_q;
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [15:0]   idx_q;
  req_t          req_q;
  logic          row_end;
  logic          last;
  logic          emit;

  assign row_end = (x_q == n_across_i - XW'(1));
  assign last    = row_end && (y_q == n_down_i - YW'(1));
  assign emit    = busy_q && en_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
    end else if (req_valid_i && !busy_q) begin
      // an empty grid takes the item and issues nothing
      busy_q  <= (n_across_i != '0) && (n_down_i != '0);
      first_q <= 1'b1;
      x_q     <= '0;
      y_q     <= '0;
    end else if (emit) begin
      first_q <= 1'b0;
      if (last) begin
        busy_q <= 1'b0;
      end else if (row_end) begin
        x_q <= '0;
        y_q <= y_q + YW'(1);
      end else begin
        x_q <= x_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && !busy_q) begin
      idx_q <= req_i.start_vertex;
      req_q <= req_i;
    end else if (emit) begin
      idx_q <= idx_q + (first_q ? IDX_STEP_FIRST : IDX_STEP);
    end
  end

  assign req_ready_o           = !busy_q;
  assign tile_valid_o          = busy_q;
  assign tile_x_o              = x_q;
  assign tile_y_o              = y_q;
  assign tag_o.first_index     = idx_q;
  assign tag_o.stitch_previous = first_q && (idx_q != 16'd0);
  assign tag_o.last_tile       = last;
  assign req_o                 = req_q;

  `TQSVG_ASSERT_NEXT(a_last_ends_run, clk_i, rst_ni, emit && last, !busy_q,
    "sequencer still busy after the last tile")
  `TQSVG_ASSERT_NEXT(a_first_step, clk_i, rst_ni, emit && first_q && !last,
    idx_q == $past(idx_q) + IDX_STEP_FIRST, "wrong index step after the first tile")
  `TQSVG_ASSERT_NEXT(a_later_step, clk_i, rst_ni, emit && !first_q && !last,
    idx_q == $past(idx_q) + IDX_STEP, "wrong index step after a later tile")

endmodule

`default_nettype wire

// ===== src/tqsvg_xform.sv =====
// optional affine transform of four tile corners: product, then sum stage
// depends on tqsvg_pkg
`default_nettype none

module tqsvg_xform import tqsvg_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      valid_i,
  input  wire tile_tag_t tag_i,
  input  wire req_t      req_i,
  input  wire local_t    loc_i,
  output logic           valid_o,
  output result_t        res_o
);

  logic signed [63:0] m_xx0, m_xx1, m_xy0, m_xy1;
  logic signed [63:0] m_yx0, m_yx1, m_yy0, m_yy1;

  logic        p_valid_q;
  tile_tag_t   p_tag_q;
  logic        p_xf_q;
  logic [31:0] p_ox_q, p_oy_q;
  local_t      p_loc_q;
  logic [31:0] p_xx0_q, p_xx1_q, p_xy0_q, p_xy1_q;
  logic [31:0] p_yx0_q, p_yx1_q, p_yy0_q, p_yy1_q;

  logic        r_valid_q;
  result_t     r_res_q;

  assign m_xx0 = $signed(req_i.coef_xx) * $signed(loc_i.x0);
  assign m_xx1 = $signed(req_i.coef_xx) * $signed(loc_i.x1);
  assign m_xy0 = $signed(req_i.coef_xy) * $signed(loc_i.y0);
  assign m_xy1 = $signed(req_i.coef_xy) * $signed(loc_i.y1);
  assign m_yx0 = $signed(req_i.coef_yx) * $signed(loc_i.x0);
  assign m_yx1 = $signed(req_i.coef_yx) * $signed(loc_i.x1);
  assign m_yy0 = $signed(req_i.coef_yy) * $signed(loc_i.y0);
  assign m_yy1 = $signed(req_i.coef_yy) * $signed(loc_i.y1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
    end else if (en_i) begin
      p_valid_q <= valid_i;
      r_valid_q <= p_valid_q;
    end
  end

  // bits 47:16 of the full product give the floor of the q16.16 product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_tag_q <= tag_i;
      p_xf_q  <= req_i.apply_transform;
      p_ox_q  <= req_i.offset_x;
      p_oy_q  <= req_i.offset_y;
      p_loc_q <= loc_i;
      p_xx0_q <= m_xx0[47:16];
      p_xx1_q <= m_xx1[47:16];
      p_xy0_q <= m_xy0[47:16];
      p_xy1_q <= m_xy1[47:16];
      p_yx0_q <= m_yx0[47:16];
      p_yx1_q <= m_yx1[47:16];
      p_yy0_q <= m_yy0[47:16];
      p_yy1_q <= m_yy1[47:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_res_q.tag <= p_tag_q;
      if (p_xf_q) begin
        r_res_q.top_left_x     <= p_xx0_q + p_xy0_q + p_ox_q;
        r_res_q.top_left_y     <= p_yx0_q + p_yy0_q + p_oy_q;
        r_res_q.bottom_left_x  <= p_xx0_q + p_xy1_q + p_ox_q;
        r_res_q.bottom_left_y  <= p_yx0_q + p_yy1_q + p_oy_q;
        r_res_q.top_right_x    <= p_xx1_q + p_xy0_q + p_ox_q;
        r_res_q.top_right_y    <= p_yx1_q + p_yy0_q + p_oy_q;
        r_res_q.bottom_right_x <= p_xx1_q + p_xy1_q + p_ox_q;
        r_res_q.bottom_right_y <= p_yx1_q + p_yy1_q + p_oy_q;
      end else begin
        r_res_q.top_left_x     <= p_loc_q.x0;
        r_res_q.top_left_y     <= p_loc_q.y0;
        r_res_q.bottom_left_x  <= p_loc_q.x0;
        r_res_q.bottom_left_y  <= p_loc_q.y1;
        r_res_q.top_right_x    <= p_loc_q.x1;
        r_res_q.top_right_y    <= p_loc_q.y0;
        r_res_q.bottom_right_x <= p_loc_q.x1;
        r_res_q.bottom_right_y <= p_loc_q.y1;
      end
    end
  end

  assign valid_o = r_valid_q;
  assign res_o   = r_res_q;

endmodule

`default_nettype wire

// ===== tb/tiled_quad_strip_vertex_generator_unit_tb.sv =====
// self-checking bench for tiled_quad_strip_vertex_generator_unit: draw requests in, tile
// corners out, compared against a tile predictor kept in a small scoreboard class
// depends on tqsvg_pkg and the unit under src
module tiled_quad_strip_vertex_generator_unit_tb;
  import tqsvg_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 430;
  localparam int MAX_ACROSS    = 8;
  localparam int MAX_DOWN      = 8;
  // register index past the end of the map, the unit must drop the write
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  typedef enum int {SINK_OPEN, SINK_HALF, SINK_LIGHT, SINK_HEAVY} sink_mode_e;

  // corner[0..7] in the order they sit in tdata, lowest first
  typedef struct packed {
    logic [7:0][31:0] corner;
    logic [15:0]      first_index;
    logic             stitch;
    logic             last;
  } tile_t;

  class quad_tile_board;
    logic [3:0]  across;
    logic [3:0]  down;
    logic [30:0] tile_w;
    logic [30:0] tile_h;
    logic [30:0] area_w;
    logic [30:0] area_h;
    logic        vis;
    tile_t       pending_tiles[$];
    int unsigned errors;
    string       corner_name[8] = '{"top_left_x", "top_left_y", "bottom_left_x",
                                    "bottom_left_y", "top_right_x", "top_right_y",
                                    "bottom_right_x", "bottom_right_y"};

    function new();
      across = 4'd1;
      down   = 4'd1;
      tile_w = 31'd65536;
      tile_h = 31'd65536;
      area_w = 31'd65536;
      area_h = 31'd65536;
      vis    = 1'b1;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_TILES_ACROSS: across = data[3:0];
        CFG_TILES_DOWN:   down   = data[3:0];
        CFG_TILE_WIDTH:   tile_w = data[30:0];
        CFG_TILE_HEIGHT:  tile_h = data[30:0];
        CFG_AREA_WIDTH:   area_w = data[30:0];
        CFG_AREA_HEIGHT:  area_h = data[30:0];
        CFG_VISIBLE:      vis    = data[0];
        default: ;
      endcase
    endfunction

    // q16.16 product, floor rounding, wrapped to 32 bits
    function logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
      logic signed [63:0] p;
      p = $signed(a) * $signed(b);
      return p[47:16];
    endfunction

    function int unsigned pending();
      return pending_tiles.size();
    endfunction

    function void add_request(req_t r);
      int unsigned nx, ny, k;
      logic [63:0] near_e, far_e;
      logic [31:0] x0, x1, y0, y1;
      logic [31:0] lx [4];
      logic [31:0] ly [4];
      logic [15:0] idx;
      tile_t t;
      nx = (across > MAX_ACROSS) ? MAX_ACROSS : across;
      ny = (down > MAX_DOWN) ? MAX_DOWN : down;
      idx = r.start_vertex;
      k = 0;
      for (int yi = 0; yi < ny; yi++) begin
        y0 = '0;
        y1 = '0;
        if (vis) begin
          near_e = 64'(tile_h) * 64'(yi);
          far_e  = 64'(tile_h) * 64'(yi + 1);
          y0 = near_e[31:0];
          y1 = (far_e > 64'(area_h)) ? 32'(area_h) : far_e[31:0];
        end
        for (int xi = 0; xi < nx; xi++) begin
          x0 = '0;
          x1 = '0;
          if (vis) begin
            near_e = 64'(tile_w) * 64'(xi);
            far_e  = 64'(tile_w) * 64'(xi + 1);
            x0 = near_e[31:0];
            x1 = (far_e > 64'(area_w)) ? 32'(area_w) : far_e[31:0];
          end
          lx[0] = x0; ly[0] = y0;
          lx[1] = x0; ly[1] = y1;
          lx[2] = x1; ly[2] = y0;
          lx[3] = x1; ly[3] = y1;
          for (int c = 0; c < 4; c++) begin
            if (r.apply_transform) begin
              t.corner[2*c]   = fx_mul(r.coef_xx, lx[c]) + fx_mul(r.coef_xy, ly[c]) + r.offset_x;
              t.corner[2*c+1] = fx_mul(r.coef_yx, lx[c]) + fx_mul(r.coef_yy, ly[c]) + r.offset_y;
            end else begin
              t.corner[2*c]   = lx[c];
              t.corner[2*c+1] = ly[c];
            end
          end
          if (k > 0) idx = idx + ((k == 1) ? IDX_STEP_FIRST : IDX_STEP);
          t.first_index = idx;
          t.stitch      = (k == 0) && (r.start_vertex != 0);
          t.last        = (k + 1 == nx * ny);
          pending_tiles.push_back(t);
          k++;
        end
      end
    endfunction

    function void mismatch(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10) $display("tile mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_tile(logic [271:0] data, logic stitch, logic last);
      tile_t want;
      if (pending_tiles.size() == 0) begin
        mismatch("tile with nothing pending", '0, data[31:0]);
        return;
      end
      want = pending_tiles.pop_front();
      for (int c = 0; c < 8; c++)
        if (data[c*32 +: 32] !== want.corner[c])
          mismatch(corner_name[c], want.corner[c], data[c*32 +: 32]);
      if (data[271:256] !== want.first_index)
        mismatch("first_index", 32'(want.first_index), 32'(data[271:256]));
      if (stitch !== want.stitch) mismatch("stitch_previous", 32'(want.stitch), 32'(stitch));
      if (last !== want.last) mismatch("last_tile", 32'(want.last), 32'(last));
    endfunction
  endclass

  logic           clk_i     = 1'b0;
  logic           rst_ni    = 1'b0;
  logic           s_tvalid  = 1'b0;
  logic [207:0]   s_tdata   = '0;
  logic [0:0]     s_tuser   = '0;
  logic           m_tready  = 1'b0;
  logic           cfg_valid = 1'b0;
  logic [2:0]     cfg_index = '0;
  logic [31:0]    cfg_data  = '0;
  wire            s_tready;
  wire            m_tvalid;
  wire  [271:0]   m_tdata;
  wire  [0:0]     m_tuser;
  wire            m_tlast;
  wire            cfg_ready;

  quad_tile_board board;
  int             burst_left = 0;

  tiled_quad_strip_vertex_generator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) board.check_tile(m_tdata, m_tuser[0], m_tlast);
  end

  // receiver back-pressure, switching between stall patterns
  initial begin : result_sink
    sink_mode_e mode;
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      repeat ($urandom_range(20, 300)) begin
        @(posedge clk_i);
        case (mode)
          SINK_OPEN:  m_tready <= 1'b1;
          SINK_HALF:  m_tready <= ($urandom_range(0, 1) == 1);
          SINK_LIGHT: m_tready <= ($urandom_range(0, 7) != 0);
          default:    m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic req_t make_request(logic [15:0] sv, logic xf, logic [31:0] cxx,
                                        logic [31:0] cyx, logic [31:0] cxy, logic [31:0] cyy,
                                        logic [31:0] ox, logic [31:0] oy);
    req_t r;
    r.start_vertex    = sv;
    r.apply_transform = xf;
    r.coef_xx         = cxx;
    r.coef_yx         = cyx;
    r.coef_xy         = cxy;
    r.coef_yy         = cyy;
    r.offset_x        = ox;
    r.offset_y        = oy;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0, 1: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      2: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return '0;
          3:       return '1;
          default: return 32'h0001_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] rand_size(int unsigned span);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 31'h7FFF_FFFF;
      2:       return 31'($urandom());
      default: return 31'($urandom_range(0, span));
    endcase
  endfunction

  function automatic logic [3:0] rand_count();
    case ($urandom_range(0, 19))
      0:       return 4'd0;
      1, 2:    return 4'($urandom_range(5, 15));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic req_t rand_request();
    logic [15:0] sv;
    case ($urandom_range(0, 7))
      0, 1:    sv = '0;
      2:       sv = 16'($urandom_range(16'hFF00, 16'hFFFF));
      default: sv = 16'($urandom());
    endcase
    return make_request(sv, ($urandom_range(0, 3) != 0), rand_word(), rand_word(),
                        rand_word(), rand_word(), rand_word(), rand_word());
  endfunction

  task automatic send_request(input req_t r);
    s_tvalid <= 1'b1;
    s_tdata  <= {r.offset_y, r.offset_x, r.coef_yy, r.coef_xy, r.coef_yx, r.coef_xx,
                 r.start_vertex};
    s_tuser  <= r.apply_transform;
    do @(posedge clk_i); while (!s_tready);
    board.add_request(r);
  endtask

  task automatic send_paced(input req_t r);
    int gap;
    send_request(r);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // hold off until every predicted tile has come out, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  // unused upper data bits carry noise, the unit must mask them
  task automatic setup_grid(input logic [3:0] a, input logic [3:0] d, input logic [30:0] tw,
                            input logic [30:0] th, input logic [30:0] aw, input logic [30:0] ah,
                            input logic v);
    drain();
    cfg_write(CFG_TILES_ACROSS, {28'($urandom()), a});
    cfg_write(CFG_TILES_DOWN, {28'($urandom()), d});
    cfg_write(CFG_TILE_WIDTH, {1'($urandom()), tw});
    cfg_write(CFG_TILE_HEIGHT, {1'($urandom()), th});
    cfg_write(CFG_AREA_WIDTH, {1'($urandom()), aw});
    cfg_write(CFG_AREA_HEIGHT, {1'($urandom()), ah});
    cfg_write(CFG_VISIBLE, {31'($urandom()), v});
    if ($urandom_range(0, 1) == 1) cfg_write(CFG_UNUSED, $urandom());
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned counted;
    logic [3:0]  a;
    logic [3:0]  d;
    board = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: one unit tile
    send_paced(make_request(16'd0, 1'b0, '0, '0, '0, '0, '0, '0));
    send_paced(make_request(16'hFFFF, 1'b1, 32'h0001_0000, '0, '0, 32'h0001_0000, '0, '0));
    send_paced(make_request(16'd1, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_paced(make_request(16'h8000, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, '1, '1));

    // full grid with huge tiles: near edges wrap, index wraps past 16 bits
    setup_grid(4'd8, 4'd8, 31'h7FFF_FFFF, 31'h4000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    send_paced(make_request(16'hFFF0, 1'b0, '0, '0, '0, '0, '0, '0));
    send_paced(make_request(16'h0000, 1'b1, '1, '1, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF));
    send_paced(rand_request());

    // counts above the limit saturate, inactive block with and without transform
    setup_grid(4'd15, 4'd9, 31'h0001_8000, 31'h0001_8000, 31'h0005_0000, 31'h0005_0000, 1'b0);
    send_paced(make_request(16'h0007, 1'b1, rand_word(), rand_word(), rand_word(),
                            rand_word(), $urandom(), $urandom()));
    send_paced(make_request(16'h0000, 1'b0, '0, '0, '0, '0, '0, '0));

    // empty grids, nothing comes out
    setup_grid(4'd0, 4'd3, 31'h0001_0000, 31'h0001_0000, 31'h0004_0000, 31'h0004_0000, 1'b1);
    send_paced(rand_request());
    send_paced(rand_request());
    setup_grid(4'd3, 4'd0, 31'h0001_0000, 31'h0001_0000, 31'h0004_0000, 31'h0004_0000, 1'b1);
    send_paced(rand_request());

    // zero sizes, one column
    setup_grid(4'd1, 4'd8, '0, '0, '0, '0, 1'b1);
    send_paced(rand_request());
    send_paced(make_request(16'h1234, 1'b1, '0, '0, '0, '0, 32'h8000_0000, '1));

    // one row clipped at the right, bottom clipped to zero
    setup_grid(4'd8, 4'd1, 31'h0001_0000, 31'h0002_0000, 31'h0003_8000, '0, 1'b1);
    send_paced(rand_request());
    send_paced(make_request(16'h0010, 1'b1, 32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000,
                            32'hFFFF_FFFF, 32'h0010_0000, 32'hFFF0_0000));

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      a = rand_count();
      d = rand_count();
      setup_grid(a, d, rand_size(32'h0004_0000), rand_size(32'h0004_0000),
                 rand_size(32'h0020_0000), rand_size(32'h0020_0000),
                 ($urandom_range(0, 4) != 0));
      repeat ($urandom_range(8, 40)) begin
        send_paced(rand_request());
        counted++;
      end
    end
    drain();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("[tiled_quad_strip_vertex_generator_unit] OK");
    end else begin
      $display("[tiled_quad_strip_vertex_generator_unit] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("[tiled_quad_strip_vertex_generator_unit] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/tqsvg_pkg.sv
src/tqsvg_tile_seq.sv
src/tqsvg_xform.sv
src/tiled_quad_strip_vertex_generator_unit.sv
tb/tiled_quad_strip_vertex_generator_unit_tb.sv
